// ----- src/flog_pkg.sv -----
// Shared types, constants and command codes for the flow log recency table.
// Used by flog_ctrl, flog_datapath, flow_log_mru_table and its checker.
package flog_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // request command codes
   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_READ   = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // response status codes
   localparam logic [2:0] STS_UPDATED  = 3'd0;
   localparam logic [2:0] STS_INSERTED = 3'd1;
   localparam logic [2:0] STS_FULL     = 3'd2;
   localparam logic [2:0] STS_READ_OK  = 3'd3;
   localparam logic [2:0] STS_PAST_END = 3'd4;
   localparam logic [2:0] STS_CLEARED  = 3'd5;

   // index counter operations
   localparam logic [1:0] IDX_HOLD = 2'd0;
   localparam logic [1:0] IDX_ZERO = 2'd1;
   localparam logic [1:0] IDX_INC  = 2'd2;
   localparam logic [1:0] IDX_DEC  = 2'd3;

   // memory read address sources
   localparam logic [1:0] RD_SCAN  = 2'd0;
   localparam logic [1:0] RD_SHIFT = 2'd1;
   localparam logic [1:0] RD_POS   = 2'd2;

   typedef struct packed {
      logic [1:0]        command;
      logic [31:0]       source_address;
      logic [31:0]       destination_address;
      logic [15:0]       source_port;
      logic [15:0]       destination_port;
      logic [7:0]        protocol_number;
      logic [7:0]        verdict;
      logic signed [7:0] reason_code;
      logic [31:0]       now_seconds;
      logic [5:0]        read_position;
   } req_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [31:0]       row_timestamp;
      logic [31:0]       row_source_address;
      logic [31:0]       row_destination_address;
      logic [15:0]       row_source_port;
      logic [15:0]       row_destination_port;
      logic [7:0]        row_protocol;
      logic [7:0]        row_verdict;
      logic signed [7:0] row_reason;
      logic [31:0]       row_hits;
      logic [6:0]        entries_in_use;
   } rsp_type;

   typedef struct packed {
      logic [31:0]       src_addr;
      logic [31:0]       dst_addr;
      logic [15:0]       sport;
      logic [15:0]       dport;
      logic [7:0]        proto;
      logic [7:0]        verdict;
      logic signed [7:0] reason;
      logic [31:0]       last_seen;
      logic [31:0]       hits;
   } slot_type;

   // controller to datapath
   typedef struct packed {
      logic       load_req;
      logic       rd_en;
      logic [1:0] rd_sel;
      logic [1:0] idx_op;
      logic       wr_shift;
      logic       wr_front;
      logic       hits_capture;
      logic       hits_one;
      logic       used_inc;
      logic       used_clear;
      logic       rsp_load;
      logic [2:0] rsp_status;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] command;
      logic       key_match;
      logic       idx_last;
      logic       idx_zero;
      logic       used_zero;
      logic       full;
      logic       pos_ok;
   } dp_stat_type;

endpackage

// ----- src/flow_log_mru_table.sv -----
// Top level of the flow log recency table: joins flog_ctrl and flog_datapath.
// Depends on flog_pkg.
//
// A request is taken when start is high while busy is low; busy then stays high
// until the request has finished. Each request yields one response, shown for a
// single cycle with rsp_valid high; the receiver cannot stall it, so capture it
// then. Entries live in one single-port-read memory in recency order, position 0
// most recent. A read, clear or unused command passes through the decode and
// done states. An add walks the table, with a read and a compare state per
// entry, to find a match, then moves every entry in front of the hit (or all
// entries, for an insert) back one place, with a read and a write state per
// entry through the same memory port, then writes the new front; a rejected
// add to a full table skips the shift and the front write. rsp_valid rises in
// the same cycle that busy falls. The memory needs no clearing after reset;
// only positions below entries_in_use are ever looked at.
module flow_log_mru_table
   import flog_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   ctl_cmd_type cmd;
   dp_stat_type stat;

   // sequence the scan, shift and front write
   flog_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // hold the table, the request and the response register
   flog_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- src/flog_datapath.sv -----
// Datapath of the flow log table: entry memory, request and response registers,
// scan/shift index and fill count. Depends on flog_pkg.
module flog_datapath
   import flog_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  ctl_cmd_type cmd,
   output dp_stat_type stat,
   output logic        rsp_valid,
   output rsp_type     rsp_data
);

   slot_type          mem [TABLE_DEPTH];
   slot_type          rdata_ff;
   req_type           req_ff;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  used_ff, used_in;
   logic [31:0]       hits_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff, rsp_in;
   logic [ADDR_W-1:0] rd_addr;
   logic [CNT_W-1:0]  idx_dec;
   slot_type          front;

   assign idx_dec = idx_ff - CNT_W'(1);

   always_comb begin
      case (cmd.rd_sel)
         RD_SHIFT: rd_addr = idx_dec[ADDR_W-1:0];
         RD_POS:   rd_addr = ADDR_W'(req_ff.read_position);
         default:  rd_addr = idx_ff[ADDR_W-1:0];
      endcase
   end

   always_comb begin
      front.src_addr  = req_ff.source_address;
      front.dst_addr  = req_ff.destination_address;
      front.sport     = req_ff.source_port;
      front.dport     = req_ff.destination_port;
      front.proto     = req_ff.protocol_number;
      front.verdict   = req_ff.verdict;
      front.reason    = req_ff.reason_code;
      front.last_seen = req_ff.now_seconds;
      front.hits      = hits_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_shift) begin
         mem[idx_ff[ADDR_W-1:0]] <= rdata_ff;
      end else if (cmd.wr_front) begin
         mem[0] <= front;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.hits_capture) begin
         hits_ff <= (rdata_ff.hits == 32'hFFFF_FFFF) ? rdata_ff.hits : rdata_ff.hits + 32'd1;
      end else if (cmd.hits_one) begin
         hits_ff <= 32'd1;
      end
   end

   always_comb begin
      case (cmd.idx_op)
         IDX_ZERO: idx_in = '0;
         IDX_INC:  idx_in = idx_ff + CNT_W'(1);
         IDX_DEC:  idx_in = idx_dec;
         default:  idx_in = idx_ff;
      endcase
      if (cmd.used_clear) begin
         used_in = '0;
      end else if (cmd.used_inc) begin
         used_in = used_ff + CNT_W'(1);
      end else begin
         used_in = used_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         used_ff      <= used_in;
         rsp_valid_ff <= cmd.rsp_load;
      end
   end

   // build the response; only a successful read shows the whole row, an add that updates or inserts shows the hit count
   always_comb begin
      rsp_in                = '0;
      rsp_in.status         = cmd.rsp_status;
      rsp_in.entries_in_use = 7'(used_ff);
      if (cmd.rsp_status == STS_READ_OK) begin
         rsp_in.row_timestamp           = rdata_ff.last_seen;
         rsp_in.row_source_address      = rdata_ff.src_addr;
         rsp_in.row_destination_address = rdata_ff.dst_addr;
         rsp_in.row_source_port         = rdata_ff.sport;
         rsp_in.row_destination_port    = rdata_ff.dport;
         rsp_in.row_protocol            = rdata_ff.proto;
         rsp_in.row_verdict             = rdata_ff.verdict;
         rsp_in.row_reason              = rdata_ff.reason;
         rsp_in.row_hits                = rdata_ff.hits;
      end else if (cmd.rsp_status == STS_UPDATED || cmd.rsp_status == STS_INSERTED) begin
         rsp_in.row_hits = hits_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign stat.command   = req_ff.command;
   assign stat.key_match = rdata_ff.src_addr == req_ff.source_address &&
                           rdata_ff.dst_addr == req_ff.destination_address &&
                           rdata_ff.sport == req_ff.source_port &&
                           rdata_ff.dport == req_ff.destination_port &&
                           rdata_ff.proto == req_ff.protocol_number &&
                           rdata_ff.verdict == req_ff.verdict &&
                           rdata_ff.reason == req_ff.reason_code;
   assign stat.idx_last  = (idx_ff + CNT_W'(1)) == used_ff;
   assign stat.idx_zero  = idx_ff == '0;
   assign stat.used_zero = used_ff == '0;
   assign stat.full      = used_ff == CNT_W'(TABLE_DEPTH);
   assign stat.pos_ok    = {{(CNT_W > 6 ? CNT_W - 6 : 0){1'b0}}, req_ff.read_position} < used_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- src/flog_ctrl.sv -----
// Sequencer of the flow log table: scan, shift, front write and response.
// Depends on flog_pkg; drives flog_datapath through ctl_cmd_type.
module flog_ctrl
   import flog_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  dp_stat_type stat,
   output ctl_cmd_type cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DECODE   = 4'd1;
   localparam logic [3:0] S_SCAN_RD  = 4'd2;
   localparam logic [3:0] S_SCAN_CMP = 4'd3;
   localparam logic [3:0] S_SHIFT_RD = 4'd4;
   localparam logic [3:0] S_SHIFT_WR = 4'd5;
   localparam logic [3:0] S_FRONT_WR = 4'd6;
   localparam logic [3:0] S_DONE     = 4'd7;

   logic [3:0] state_ff, state_in;
   logic [2:0] status_ff, status_in;

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      cmd       = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.idx_op = IDX_ZERO;
            case (stat.command)
               CMD_ADD: begin
                  if (stat.used_zero) begin
                     cmd.hits_one = 1'b1;
                     status_in    = STS_INSERTED;
                     state_in     = S_SHIFT_RD;
                  end else begin
                     state_in = S_SCAN_RD;
                  end
               end
               CMD_READ: begin
                  if (stat.pos_ok) begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_POS;
                     status_in  = STS_READ_OK;
                  end else begin
                     status_in = STS_PAST_END;
                  end
                  state_in = S_DONE;
               end
               CMD_CLEAR: begin
                  cmd.used_clear = 1'b1;
                  status_in      = STS_CLEARED;
                  state_in       = S_DONE;
               end
               default: begin
                  status_in = STS_PAST_END;
                  state_in  = S_DONE;
               end
            endcase
         end
         S_SCAN_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_SCAN;
            state_in   = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            if (stat.key_match) begin
               // hold index at the hit; entries above it move down one
               cmd.hits_capture = 1'b1;
               status_in        = STS_UPDATED;
               state_in         = S_SHIFT_RD;
            end else if (stat.idx_last) begin
               if (stat.full) begin
                  status_in = STS_FULL;
                  state_in  = S_DONE;
               end else begin
                  cmd.idx_op   = IDX_INC;
                  cmd.hits_one = 1'b1;
                  status_in    = STS_INSERTED;
                  state_in     = S_SHIFT_RD;
               end
            end else begin
               cmd.idx_op = IDX_INC;
               state_in   = S_SCAN_RD;
            end
         end
         S_SHIFT_RD: begin
            if (stat.idx_zero) begin
               state_in = S_FRONT_WR;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_SHIFT;
               state_in   = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            cmd.wr_shift = 1'b1;
            cmd.idx_op   = IDX_DEC;
            state_in     = S_SHIFT_RD;
         end
         S_FRONT_WR: begin
            cmd.wr_front = 1'b1;
            cmd.used_inc = status_ff == STS_INSERTED;
            state_in     = S_DONE;
         end
         S_DONE: begin
            cmd.rsp_load   = 1'b1;
            cmd.rsp_status = status_ff;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         status_ff <= STS_PAST_END;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
   end

   assign busy = state_ff != S_IDLE;

endmodule

// ----- src/flog_checker.sv -----
// Port-level checks for flow_log_mru_table and the bind that attaches them.
// Depends on flog_pkg.
module flog_checker
   import flog_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy not raised after request");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response strobe longer than one cycle");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.entries_in_use <= 7'(TABLE_DEPTH))
      else $error("entries_in_use beyond table depth");

   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STS_CLEARED |-> rsp_data.entries_in_use == 7'd0)
      else $error("clear left entries");

endmodule

bind flow_log_mru_table flog_checker u_flog_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
